@@ hdl/sstk_pkg.sv @@
// Shared types and constants for the searchable stack.
// Holds request modes, status codes and payload widths; no dependencies.
`timescale 1ns / 1ps

package sstk_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned OCC_W           = 5;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_EDIT   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

@@ hdl/sstk_if.sv @@
// Valid/ready channel interfaces for searchable stack requests and responses.
// Depends on sstk_pkg for the payload types.
`timescale 1ns / 1ps

interface sstk_req_if import sstk_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_e mode;
  data_t key_value;
  data_t new_value;

  modport source (output valid, mode, key_value, new_value, input ready);
  modport sink (input valid, mode, key_value, new_value, output ready);
  modport monitor (input valid, ready, mode, key_value, new_value);
endinterface

interface sstk_rsp_if import sstk_pkg::*; ();
  logic             valid;
  logic             ready;
  status_e          status;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, status, occupancy, input ready);
  modport sink (input valid, status, occupancy, output ready);
  modport monitor (input valid, ready, status, occupancy);
endinterface

@@ hdl/searchable_stack.sv @@
// Sequence: a push, or any request on an empty stack, goes from IDLE to DONE and then to the
// response register; a search makes one memory read per cycle, top entry first, and a remove
// then shifts every entry above the match down by one slot before DONE.
// Flow: one request at a time; a new request is taken once the previous one has reached
// the response register.
// Reset: clears the entry count, the sequencer and the response register; memory is unchanged.
`timescale 1ns / 1ps

module searchable_stack import sstk_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  sstk_req_if.sink   req_i,
  sstk_rsp_if.source rsp_o
);

  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  // Sequencer: IDLE takes a request, SEARCH walks the store from the top,
  // SHIFT closes the gap after a removal, DONE hands the result over.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;       // entries held; entry 0 is the bottom
  mode_e            mode_q, mode_d;
  data_t            key_q, key_d;
  data_t            new_q, new_d;
  status_e          sts_q, sts_d;

  // ptr/left: next read address and reads still to issue (search and shift).
  // pend/pend_addr: a read is in flight and the address it came from; in
  // SHIFT the address is the destination one below it.
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;

  // Response register parts the sequencer from the sink.
  logic             rsp_vld_q, rsp_vld_d;
  status_e          rsp_sts_q, rsp_sts_d;
  logic [OCC_W-1:0] rsp_occ_q, rsp_occ_d;

  // Stack store: one write and one registered read per cycle.
  data_t             mem [STACK_DEPTH];
  data_t             rdata_q;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  data_t             wdata;

  logic                   hit;
  logic                   slot_free;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign hit       = pend_q && (rdata_q == key_q);
  assign slot_free = !rsp_vld_q || rsp_o.ready;
  // Occupancy is the count folded into the response field width.
  assign occ_ext   = {{OCC_W{1'b0}}, cnt_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mode_d      = mode_q;
    key_d       = key_q;
    new_d       = new_q;
    sts_d       = sts_q;
    ptr_d       = ptr_q;
    left_d      = left_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    rd_en       = 1'b0;
    rd_addr     = ptr_q;
    wr_en       = 1'b0;
    wr_addr     = pend_addr_q;
    wdata       = rdata_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          mode_d = req_i.mode;
          key_d  = req_i.key_value;
          new_d  = req_i.new_value;
          pend_d = 1'b0;
          if (req_i.mode == MODE_PUSH) begin
            // Push writes straight to the slot above the top; full drops it.
            if (cnt_q == DEPTH_CNT) begin
              sts_d = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = cnt_q[ADDR_W-1:0];
              wdata   = req_i.key_value;
              cnt_d   = cnt_q + 1'b1;
              sts_d   = ST_OK;
            end
            state_d = S_DONE;
          end else if (cnt_q == '0) begin
            sts_d   = ST_EMPTY;
            state_d = S_DONE;
          end else begin
            ptr_d   = ADDR_W'(cnt_q - 1'b1);
            left_d  = cnt_q;
            state_d = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        // Issue one read per cycle from the top down and compare the read
        // that returns; a stray read after the hit is simply ignored.
        pend_d      = (left_q != '0);
        pend_addr_d = ptr_q;
        if (left_q != '0) begin
          rd_en  = 1'b1;
          ptr_d  = ptr_q - 1'b1;
          left_d = left_q - 1'b1;
        end
        if (hit) begin
          pend_d = 1'b0;
          sts_d  = ST_OK;
          case (mode_q)
            MODE_REMOVE: begin
              ptr_d   = pend_addr_q + 1'b1;
              left_d  = cnt_q - CNT_W'(pend_addr_q) - 1'b1;
              state_d = S_SHIFT;
            end
            MODE_EDIT: begin
              wr_en   = 1'b1;
              wr_addr = pend_addr_q;
              wdata   = new_q;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end else if (pend_q && (pend_addr_q == '0)) begin
          // Bottom entry compared without a hit.
          sts_d   = ST_NOT_FOUND;
          state_d = S_DONE;
        end
      end

      S_SHIFT: begin
        // Read entry p+1 and write it to p in the following cycle; writes always
        // land below every later read, so no forwarding is needed.
        pend_d      = (left_q != '0);
        pend_addr_d = ptr_q - 1'b1;
        if (left_q != '0) begin
          rd_en  = 1'b1;
          ptr_d  = ptr_q + 1'b1;
          left_d = left_q - 1'b1;
        end
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_q;
          wdata   = rdata_q;
        end
        if ((left_q == '0) && !pend_q) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Load the response register from DONE; drop it once the sink takes it.
  always_comb begin
    rsp_vld_d = rsp_vld_q;
    rsp_sts_d = rsp_sts_q;
    rsp_occ_d = rsp_occ_q;
    if ((state_q == S_DONE) && slot_free) begin
      rsp_vld_d = 1'b1;
      rsp_sts_d = sts_q;
      rsp_occ_d = occ_ext[OCC_W-1:0];
    end else if (rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    key_q       <= key_d;
    new_q       <= new_d;
    sts_q       <= sts_d;
    ptr_q       <= ptr_d;
    left_q      <= left_d;
    pend_addr_q <= pend_addr_d;
    rsp_sts_q   <= rsp_sts_d;
    rsp_occ_q   <= rsp_occ_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = rsp_vld_q;
  assign rsp_o.status    = rsp_sts_q;
  assign rsp_o.occupancy = rsp_occ_q;

endmodule

@@ hdl/sstk_chk.sv @@
// Port-level checker for the searchable stack, bound to the top level.
// Depends on sstk_pkg and the channel interfaces in sstk_if.
`timescale 1ns / 1ps

module sstk_chk import sstk_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  sstk_req_if.sink   req_i,
  sstk_rsp_if.source rsp_o
);

  // Requests taken minus responses delivered.
  logic [1:0] open_q, open_d;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_i.valid && req_i.ready;
  assign rsp_xfer = rsp_o.valid && rsp_o.ready;
  assign open_d   = open_q + {1'b0, req_xfer} - {1'b0, rsp_xfer};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=>
      rsp_o.valid && $stable(rsp_o.status) && $stable(rsp_o.occupancy))
    else $error("response changed while stalled");

  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (open_q != 2'd0) && (open_q != 2'd3))
    else $error("response without a matching request");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == ST_FULL) |->
      (STACK_DEPTH >= 32) || (rsp_o.occupancy == OCC_W'(STACK_DEPTH)))
    else $error("full status with occupancy below depth");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == ST_EMPTY) |-> (rsp_o.occupancy == '0))
    else $error("empty status with nonzero occupancy");

endmodule

bind searchable_stack sstk_chk #(.STACK_DEPTH(STACK_DEPTH)) u_sstk_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

@@ tb/sv/searchable_stack_test.sv @@
// Self-checking testbench for the searchable stack: push, remove, find and edit requests.
// Depends on sstk_pkg, the request/response interfaces and the searchable_stack top level.
`timescale 1ns / 1ps

module searchable_stack_test import sstk_pkg::*; ();

  localparam int unsigned HALF_PERIOD    = 6;
  localparam int unsigned RESET_CYCLES   = 2;
  localparam int unsigned PHASE_ITEMS    = 175;
  localparam int unsigned SEGMENT_ITEMS  = 25;
  localparam int unsigned PRESSURE_ITEMS = 30;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 50;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned POOL_SIZE      = 6;

  typedef struct packed {
    status_e          status;
    logic [OCC_W-1:0] occupancy;
  } stack_resp_t;

  // Scoreboard: keeps its own copy of the stack and a queue of the answers still owed.
  class stack_scoreboard;
    data_t       held[STACK_DEPTH_DEF];
    int unsigned depth_used;
    stack_resp_t owed_q[$];
    int unsigned mismatches;

    function new();
      depth_used = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted request to the shadow stack and queue the answer it must give.
    function void note_request(mode_e m, data_t key, data_t repl);
      stack_resp_t r;
      int          pos;
      r.status = ST_OK;
      pos      = -1;
      if (m == MODE_PUSH) begin
        if (depth_used >= STACK_DEPTH_DEF) begin
          r.status = ST_FULL;
        end else begin
          held[depth_used] = key;
          depth_used++;
        end
      end else if (depth_used == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // scan from the top so only the match nearest the top is touched
        for (int i = int'(depth_used) - 1; i >= 0; i--) begin
          if (pos < 0 && held[i] == key) pos = i;
        end
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (m == MODE_REMOVE) begin
          for (int i = pos; i + 1 < int'(depth_used); i++) held[i] = held[i+1];
          depth_used--;
        end else if (m == MODE_EDIT) begin
          held[pos] = repl;
        end
      end
      r.occupancy = OCC_W'(depth_used);
      owed_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_response(status_e s, logic [OCC_W-1:0] occ);
      stack_resp_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("response %s/%0d with no request pending", s.name(), occ));
      end else begin
        want = owed_q.pop_front();
        if (s !== want.status)
          report_mismatch($sformatf("status %s, expected %s", s.name(), want.status.name()));
        if (occ !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d", occ, want.occupancy));
      end
    endtask

    function int unsigned owed();
      return owed_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic hold_trigger;
  int unsigned rsp_stall_pct;
  int unsigned req_idle_pct;
  int unsigned idle_cycles;
  data_t value_pool[POOL_SIZE];

  stack_scoreboard sb = new();

  sstk_req_if req_if ();
  sstk_rsp_if rsp_if ();

  searchable_stack i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Monitor both channels and run the watchdog. Everything here samples the values from
  // before the edge, since all drivers update with nonblocking assignments.
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready)
      sb.note_request(req_if.mode, req_if.key_value, req_if.new_value);
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_response(rsp_if.status, rsp_if.occupancy);
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("searchable_stack_test: FAIL");
        $finish;
      end
    end
  end

  // Response side: stall at the current rate, or hold ready low for a long stretch once
  // the main process pulses hold_trigger so the block backs up and stalls its input.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_trigger) begin
        rsp_if.ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Offer one request and hold it until the transfer; then idle at the sender's rate.
  // Valid stays high into the next request when no idle cycle is drawn.
  task automatic send_request(mode_e m, data_t key, data_t repl);
    req_if.valid     <= 1'b1;
    req_if.mode      <= m;
    req_if.key_value <= key;
    req_if.new_value <= repl;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Draw mostly from a small pool so searches hit and duplicates pile up.
  function automatic data_t pick_value();
    if ($urandom_range(99) < 70) return value_pool[$urandom_range(POOL_SIZE-1)];
    return data_t'($urandom());
  endfunction

  // One random request; push_pct steers the stack toward full or toward empty.
  task automatic random_request(int unsigned push_pct);
    mode_e       m;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < push_pct) begin
      m = MODE_PUSH;
    end else begin
      pick = $urandom_range(99);
      if (pick < 40)      m = MODE_REMOVE;
      else if (pick < 65) m = MODE_FIND;
      else                m = MODE_EDIT;
    end
    send_request(m, pick_value(), pick_value());
  endtask

  // Run one idling phase in segments, each with its own push bias.
  task automatic random_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned push_pct;
    req_idle_pct   = idle_pct;
    rsp_stall_pct <= stall_pct;
    for (int s = 0; s < PHASE_ITEMS / SEGMENT_ITEMS; s++) begin
      push_pct = 25 * $urandom_range(1, 3);
      repeat (SEGMENT_ITEMS) random_request(push_pct);
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    hold_trigger     <= 1'b0;
    idle_cycles      <= 0;
    rsp_stall_pct    <= 0;
    req_idle_pct      = 0;
    req_if.valid     <= 1'b0;
    req_if.mode      <= MODE_PUSH;
    req_if.key_value <= '0;
    req_if.new_value <= '0;
    value_pool[0] = 32'sh7FFF_FFFF;
    value_pool[1] = 32'sh8000_0000;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    value_pool[4] = data_t'($urandom());
    value_pool[5] = data_t'($urandom());
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: searches on an empty stack, extremes, duplicates, full stack.
    send_request(MODE_REMOVE, 32'sd5, 32'sd0);
    send_request(MODE_FIND, 32'sd5, 32'sd0);
    send_request(MODE_EDIT, 32'sd5, 32'sd9);
    send_request(MODE_PUSH, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(MODE_PUSH, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_request(MODE_PUSH, 32'sd0, -32'sd1);
    send_request(MODE_PUSH, -32'sd1, 32'sd0);
    send_request(MODE_PUSH, 32'sh7FFF_FFFF, 32'sd0);
    send_request(MODE_FIND, 32'sh7FFF_FFFF, 32'sd0);
    send_request(MODE_FIND, 32'sd12345, 32'sd0);
    // edit and remove must touch only the copy nearest the top
    send_request(MODE_EDIT, 32'sh7FFF_FFFF, 32'sd5);
    send_request(MODE_REMOVE, 32'sh8000_0000, 32'sd0);
    send_request(MODE_REMOVE, 32'sh7FFF_FFFF, 32'sd0);
    send_request(MODE_FIND, 32'sh7FFF_FFFF, 32'sd0);
    send_request(MODE_REMOVE, 32'sd77, 32'sd0);
    // three entries are held here: fill to the brim, then one push that must be dropped
    for (int i = 0; i < STACK_DEPTH_DEF - 3; i++) send_request(MODE_PUSH, pick_value(), 32'sd0);
    send_request(MODE_PUSH, 32'sd42, 32'sd0);

    // Random phases: no idling, sender idling, receiver stalling, both.
    random_phase(0, 0);
    random_phase(60, 0);
    random_phase(0, 60);
    random_phase(18, 18);

    // Pressure: hold the receiver off while the sender keeps offering requests.
    req_idle_pct   = 0;
    rsp_stall_pct <= 0;
    hold_trigger  <= 1'b1;
    @(posedge clk_i);
    hold_trigger  <= 1'b0;
    repeat (PRESSURE_ITEMS) random_request(50);
    req_if.valid <= 1'b0;

    // Drain: wait for every owed response, then a little longer for strays.
    while (sb.owed() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("searchable_stack_test: PASS");
    end else begin
      $display("searchable_stack_test: FAIL");
    end
    $finish;
  end

endmodule
